### design/hack_line_assembler_top_defines.svh
// ----------------------------------------------------------------------------
// Hack line assembler assertion macros
// Shared concurrent-check macros, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HACK_LINE_ASSEMBLER_TOP_DEFINES_SVH
`define HACK_LINE_ASSEMBLER_TOP_DEFINES_SVH

// Same-cycle implication.
`define HLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hla_pkg.sv
// ----------------------------------------------------------------------------
// Hack line assembler package
// Payload types, line state, status codes and the Hack mnemonic tables.
// ----------------------------------------------------------------------------
package hla_pkg;

  localparam int unsigned AddrWidthDefault = 15;
  localparam int unsigned WordWidth        = 16;
  localparam int unsigned TextWidth        = 24;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharAt   = 8'h40;
  localparam logic [7:0] CharEq   = 8'h3D;
  localparam logic [7:0] CharSemi = 8'h3B;
  localparam logic [7:0] CharNul  = 8'h00;

  localparam logic [2:0] CInstrPrefix = 3'b111;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MNEMONIC = 2'd1,
    ST_LABEL    = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ADDR  = 2'd1,
    PH_TEXT  = 2'd2,
    PH_JUMP  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } hla_in_t;

  typedef struct packed {
    logic [WordWidth-1:0] machine_word;
    status_e              status;
  } hla_out_t;

  // Per-line state, address kept apart since its width is a parameter.
  typedef struct packed {
    phase_e                phase;
    logic [TextWidth-1:0]  field_text;
    logic [1:0]            field_len;
    logic [TextWidth-1:0]  dest_text;
    logic [TextWidth-1:0]  comp_text;
    status_e               line_err;
  } hla_state_t;

  typedef struct packed {
    logic       comp_hit;
    logic [6:0] comp_code;
    logic       dest_hit;
    logic [2:0] dest_code;
    logic       jump_hit;
    logic [2:0] jump_code;
  } hla_lookup_t;

  typedef struct packed {
    logic [TextWidth-1:0] text;
    logic [6:0]           code;
  } comp_entry_t;

  localparam int unsigned CompEntries = 28;
  localparam int unsigned DestEntries = 7;
  localparam int unsigned JumpEntries = 7;

  localparam comp_entry_t CompTable [CompEntries] = '{
    '{24'h000030, 7'h2A}, '{24'h000031, 7'h3F}, '{24'h002D31, 7'h3A},
    '{24'h000044, 7'h0C}, '{24'h000041, 7'h30}, '{24'h002144, 7'h0D},
    '{24'h002141, 7'h31}, '{24'h002D44, 7'h0F}, '{24'h002D41, 7'h33},
    '{24'h442B31, 7'h1F}, '{24'h412B31, 7'h37}, '{24'h442D31, 7'h0E},
    '{24'h412D31, 7'h32}, '{24'h442B41, 7'h02}, '{24'h442D41, 7'h13},
    '{24'h412D44, 7'h07}, '{24'h442641, 7'h00}, '{24'h447C41, 7'h15},
    '{24'h00004D, 7'h70}, '{24'h00214D, 7'h71}, '{24'h002D4D, 7'h73},
    '{24'h4D2B31, 7'h77}, '{24'h4D2D31, 7'h72}, '{24'h442B4D, 7'h42},
    '{24'h442D4D, 7'h53}, '{24'h4D2D44, 7'h47}, '{24'h44264D, 7'h40},
    '{24'h447C4D, 7'h55}
  };

  // Dest code is index + 1: M, D, MD, A, AM, AD, AMD.
  localparam logic [TextWidth-1:0] DestTable [DestEntries] = '{
    24'h00004D, 24'h000044, 24'h004D44, 24'h000041,
    24'h00414D, 24'h004144, 24'h414D44
  };

  // Jump code is index + 1: JGT, JEQ, JGE, JLT, JNE, JLE, JMP.
  localparam logic [TextWidth-1:0] JumpTable [JumpEntries] = '{
    24'h4A4754, 24'h4A4551, 24'h4A4745, 24'h4A4C54,
    24'h4A4E45, 24'h4A4C45, 24'h4A4D50
  };

  // First error on a line wins.
  function automatic status_e hla_flag(status_e err, status_e code);
    return (err == ST_OK) ? code : err;
  endfunction

endpackage

### design/hla_decode.sv
// ----------------------------------------------------------------------------
// Hack line assembler mnemonic decode
// Parallel match of comp, dest and jump text against the Hack tables.
// ----------------------------------------------------------------------------
module hla_decode (
  input  logic [hla_pkg::TextWidth-1:0] comp_text_i,
  input  logic [hla_pkg::TextWidth-1:0] dest_text_i,
  input  logic [hla_pkg::TextWidth-1:0] jump_text_i,
  output hla_pkg::hla_lookup_t          lookup_o
);

  always_comb begin
    lookup_o = '0;
    for (int k = 0; k < hla_pkg::CompEntries; k++) begin
      if (comp_text_i == hla_pkg::CompTable[k].text) begin
        lookup_o.comp_hit  = 1'b1;
        lookup_o.comp_code = lookup_o.comp_code | hla_pkg::CompTable[k].code;
      end
    end
    for (int k = 0; k < hla_pkg::DestEntries; k++) begin
      if (dest_text_i == hla_pkg::DestTable[k]) begin
        lookup_o.dest_hit  = 1'b1;
        lookup_o.dest_code = lookup_o.dest_code | 3'(k + 1);
      end
    end
    for (int k = 0; k < hla_pkg::JumpEntries; k++) begin
      if (jump_text_i == hla_pkg::JumpTable[k]) begin
        lookup_o.jump_hit  = 1'b1;
        lookup_o.jump_code = lookup_o.jump_code | 3'(k + 1);
      end
    end
  end

endmodule

### design/hla_step.sv
// ----------------------------------------------------------------------------
// Hack line assembler character step
// Next line state for one character, and the word when the line ends.
// ----------------------------------------------------------------------------
module hla_step #(
  parameter int unsigned ADDRESS_WIDTH = hla_pkg::AddrWidthDefault
) (
  input  hla_pkg::hla_in_t           in_data_i,
  input  hla_pkg::hla_state_t        state_i,
  input  logic [ADDRESS_WIDTH-1:0]   addr_i,
  output hla_pkg::hla_state_t        state_o,
  output logic [ADDRESS_WIDTH-1:0]   addr_o,
  output hla_pkg::hla_out_t          result_o
);

  localparam int unsigned ProdWidth = ADDRESS_WIDTH + 4;

  hla_pkg::hla_state_t         st;
  hla_pkg::hla_lookup_t        lookup;
  logic [7:0]                  c;
  logic [ProdWidth-1:0]        addr_ext;
  logic [ProdWidth-1:0]        addr_next;
  logic [hla_pkg::TextWidth-1:0] comp_part;
  logic [hla_pkg::TextWidth-1:0] jump_part;
  logic [hla_pkg::WordWidth-1:0] word;
  logic                        is_digit;
  logic                        take;

  assign c        = in_data_i.char_code;
  assign is_digit = (c >= hla_pkg::CharZero) && (c <= hla_pkg::CharNine);
  assign addr_ext = {4'b0000, addr_i};
  assign addr_next = (addr_ext << 3) + (addr_ext << 1)
                   + {{ADDRESS_WIDTH{1'b0}}, 4'(c - hla_pkg::CharZero)};

  // Per-character update.
  always_comb begin
    st     = state_i;
    addr_o = addr_i;
    take   = 1'b0;
    case (state_i.phase)
      hla_pkg::PH_START: begin
        if (c == hla_pkg::CharAt) begin
          st.phase = hla_pkg::PH_ADDR;
        end else begin
          st.phase = hla_pkg::PH_TEXT;
          take     = 1'b1;
        end
      end
      hla_pkg::PH_ADDR: begin
        if (is_digit) begin
          st.field_len = 2'd1;
          if (|addr_next[ProdWidth-1:ADDRESS_WIDTH]) begin
            st.line_err = hla_pkg::hla_flag(st.line_err, hla_pkg::ST_RANGE);
          end
          if (st.line_err == hla_pkg::ST_OK) begin
            addr_o = addr_next[ADDRESS_WIDTH-1:0];
          end
        end else begin
          st.line_err = hla_pkg::hla_flag(st.line_err, hla_pkg::ST_LABEL);
        end
      end
      default: begin
        if (c == hla_pkg::CharEq) begin
          if (state_i.phase == hla_pkg::PH_JUMP || state_i.dest_text != '0 ||
              state_i.field_len == 2'd0) begin
            st.line_err = hla_pkg::hla_flag(st.line_err, hla_pkg::ST_MNEMONIC);
          end else begin
            st.dest_text = state_i.field_text;
          end
          st.field_text = '0;
          st.field_len  = 2'd0;
        end else if (c == hla_pkg::CharSemi) begin
          if (state_i.phase == hla_pkg::PH_JUMP || state_i.field_len == 2'd0) begin
            st.line_err = hla_pkg::hla_flag(st.line_err, hla_pkg::ST_MNEMONIC);
          end else begin
            st.comp_text = state_i.field_text;
          end
          st.field_text = '0;
          st.field_len  = 2'd0;
          st.phase      = hla_pkg::PH_JUMP;
        end else begin
          take = 1'b1;
        end
      end
    endcase
    if (take) begin
      if (c == hla_pkg::CharNul) begin
        st.line_err = hla_pkg::hla_flag(st.line_err, hla_pkg::ST_MNEMONIC);
      end
      if (state_i.field_len == 2'd3) begin
        st.line_err = hla_pkg::hla_flag(st.line_err, hla_pkg::ST_MNEMONIC);
      end else begin
        st.field_text = {state_i.field_text[hla_pkg::TextWidth-9:0], c};
        st.field_len  = state_i.field_len + 2'd1;
      end
    end
  end

  assign comp_part = (st.phase == hla_pkg::PH_JUMP) ? st.comp_text : st.field_text;
  assign jump_part = (st.phase == hla_pkg::PH_JUMP) ? st.field_text : '0;

  hla_decode u_decode (
    .comp_text_i (comp_part),
    .dest_text_i (st.dest_text),
    .jump_text_i (jump_part),
    .lookup_o    (lookup)
  );

  // End-of-line checks and word assembly.
  always_comb begin
    result_o.status = st.line_err;
    if (st.phase == hla_pkg::PH_ADDR) begin
      if (st.field_len == 2'd0) begin
        result_o.status = hla_pkg::hla_flag(result_o.status, hla_pkg::ST_MNEMONIC);
      end
      word = {{(hla_pkg::WordWidth - ADDRESS_WIDTH){1'b0}}, addr_o};
    end else begin
      if (st.phase == hla_pkg::PH_JUMP && st.field_len == 2'd0) begin
        result_o.status = hla_pkg::hla_flag(result_o.status, hla_pkg::ST_MNEMONIC);
      end
      if (!lookup.comp_hit ||
          (st.dest_text != '0 && !lookup.dest_hit) ||
          (jump_part != '0 && !lookup.jump_hit)) begin
        result_o.status = hla_pkg::hla_flag(result_o.status, hla_pkg::ST_MNEMONIC);
      end
      word = {hla_pkg::CInstrPrefix, lookup.comp_code, lookup.dest_code, lookup.jump_code};
    end
    result_o.machine_word = (result_o.status == hla_pkg::ST_OK) ? word : '0;
  end

  // A finished line leaves everything cleared for the next one.
  always_comb begin
    if (in_data_i.end_of_line) begin
      state_o = '0;
    end else begin
      state_o = st;
    end
  end

endmodule

### design/hack_line_assembler_top.sv
// ----------------------------------------------------------------------------
// Hack line assembler
// Assembles one line of Hack assembly text, one character per request,
// into a single 16-bit machine word with a status code.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid_i/in_ready_o  | in_data_i  : char_code, end_of_line
//  out     | out_valid_o/out_ready_i| out_data_o : machine_word, status
//
//  One character is taken per cycle while in_ready_o is high; a line of N
//  characters gives its word in the cycle after the Nth request, from the result register.
//  The character update, table match and word build sit between the line
//  state registers and the result register, one pass per request.
//  in_ready_o drops only while a result waits and out_ready_i is low; the
//  result register then holds, and the next request goes in as it drains.
//  Reset clears the line state and empties the result register.
//
module hack_line_assembler_top #(
  parameter int unsigned ADDRESS_WIDTH = hla_pkg::AddrWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hla_pkg::hla_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hla_pkg::hla_out_t out_data_o
);

  // Line state: phase, current part text, saved dest/comp, first error.
  hla_pkg::hla_state_t       state_q, state_d;
  logic [ADDRESS_WIDTH-1:0]  addr_q, addr_d;

  // Result register.
  logic                      out_valid_q;
  hla_pkg::hla_out_t         out_data_q;
  hla_pkg::hla_out_t         result;

  logic                      in_fire;

  // The result slot is free, or frees up this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  hla_step #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_step (
    .in_data_i (in_data_i),
    .state_i   (state_q),
    .addr_i    (addr_q),
    .state_o   (state_d),
    .addr_o    (addr_d),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      addr_q  <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
      addr_q  <= in_data_i.end_of_line ? '0 : addr_d;
    end
  end

  // Only the last character of a line loads a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && in_data_i.end_of_line) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.end_of_line) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "hack_line_assembler_top_defines.svh"

  // A line end always leaves a result waiting.
  `HLA_ASSERT_NEXT(a_eol_gives_result, in_fire && in_data_i.end_of_line, out_valid_o, "line end lost its result")

  // A line end puts the state back at line start.
  `HLA_ASSERT_NEXT(a_eol_clears_line, in_fire && in_data_i.end_of_line, state_q.phase == hla_pkg::PH_START && state_q.field_len == 2'd0 && state_q.line_err == hla_pkg::ST_OK, "line state not cleared")

  // Part text is empty whenever its length is zero.
  `HLA_ASSERT_NOW(a_empty_part, state_q.field_len == 2'd0, state_q.field_text == '0, "stale part text")

endmodule
